### sv/perfect_number_test_defines.svh
// Assertion macros shared by the perfect number test checker.
`ifndef PERFECT_NUMBER_TEST_DEFINES_SVH
`define PERFECT_NUMBER_TEST_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define PNT_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion that holds at every edge, reset included.
`define PNT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/pnt_pkg.sv
// Package with the sequencer state type of the perfect number test.
package pnt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_ADD_D,
        ST_ADD_Q,
        ST_FINISH
    } state_t;

endpackage

### sv/perfect_number_test.sv
// Perfect number test: trial divisors with a bit-serial restoring divider.
//
//   channel   direction  word                          handshake
//   s_        in         candidate                     s_valid / s_ready
//   m_        out        is_perfect, tested_value      m_valid / m_ready
//
// Each trial divisor d runs a full NUMBER_WIDTH-bit division, one check state and up
// to two accumulate states; trials stop when d passes sqrt(n) or the sum exceeds n.
// The single shared divider yields one quotient bit per cycle.
// Zero and one skip the divider. Reset is synchronous and clears the sequencer
// and the output valid. A stalled result holds the block in its finish state.
module perfect_number_test #(
    parameter int NUMBER_WIDTH = 31
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [NUMBER_WIDTH-1:0] s_candidate,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_is_perfect,
    output logic [NUMBER_WIDTH-1:0] m_tested_value
);

    localparam int W     = NUMBER_WIDTH;
    localparam int CNT_W = $clog2(NUMBER_WIDTH);

    pnt_pkg::state_t state_reg, state_next;

    logic [W-1:0]     n_reg, n_next;
    logic [W-1:0]     d_reg, d_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             perf_reg, perf_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_perf_reg, out_perf_next;
    logic [W-1:0]     out_value_reg, out_value_next;

    logic [W:0]       trial;
    logic             trial_ge;
    logic [W:0]       sum_d;
    logic [W:0]       sum_q;
    logic             div_last;
    logic             out_free;

    // One restoring division step: bring down the next dividend bit.
    assign trial    = {rem_reg, dvd_reg[W-1]};
    assign trial_ge = trial >= {1'b0, d_reg};
    assign div_last = cnt_reg == CNT_W'(W - 1);
    assign sum_d    = sum_reg + {1'b0, d_reg};
    assign sum_q    = sum_reg + {1'b0, quo_reg};
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pnt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_candidate < W'(2)) ? pnt_pkg::ST_FINISH
                                                       : pnt_pkg::ST_DIV;
                end
            end
            pnt_pkg::ST_DIV: begin
                if (div_last) begin
                    state_next = pnt_pkg::ST_CHECK;
                end
            end
            pnt_pkg::ST_CHECK: begin
                priority if (d_reg > quo_reg) begin
                    state_next = pnt_pkg::ST_FINISH;
                end else if (rem_reg == '0) begin
                    state_next = pnt_pkg::ST_ADD_D;
                end else begin
                    state_next = pnt_pkg::ST_DIV;
                end
            end
            pnt_pkg::ST_ADD_D: begin
                priority if (sum_d > {1'b0, n_reg}) begin
                    state_next = pnt_pkg::ST_FINISH;
                end else if (quo_reg != d_reg && quo_reg != n_reg) begin
                    state_next = pnt_pkg::ST_ADD_Q;
                end else begin
                    state_next = pnt_pkg::ST_DIV;
                end
            end
            pnt_pkg::ST_ADD_Q: begin
                state_next = (sum_q > {1'b0, n_reg}) ? pnt_pkg::ST_FINISH
                                                     : pnt_pkg::ST_DIV;
            end
            pnt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = pnt_pkg::ST_IDLE;
                end
            end
            default: state_next = pnt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_next         = n_reg;
        d_next         = d_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        perf_next      = perf_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_perf_next  = out_perf_reg;
        out_value_next = out_value_reg;
        unique case (state_reg)
            pnt_pkg::ST_IDLE: begin
                n_next    = s_candidate;
                d_next    = W'(1);
                dvd_next  = s_candidate;
                rem_next  = '0;
                sum_next  = '0;
                cnt_next  = '0;
                perf_next = 1'b0;
            end
            pnt_pkg::ST_DIV: begin
                rem_next = trial_ge ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
                quo_next = {quo_reg[W-2:0], trial_ge};
                dvd_next = {dvd_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pnt_pkg::ST_CHECK: begin
                // The divisor has passed the square root: the sum is complete.
                // A search cut short by an oversized sum leaves the flag clear.
                if (d_reg > quo_reg) begin
                    perf_next = sum_reg == {1'b0, n_reg};
                end
                if (d_reg <= quo_reg && rem_reg != '0) begin
                    d_next   = d_reg + W'(1);
                    dvd_next = n_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            pnt_pkg::ST_ADD_D: begin
                sum_next = sum_d;
                d_next   = d_reg + W'(1);
                dvd_next = n_reg;
                rem_next = '0;
                cnt_next = '0;
            end
            pnt_pkg::ST_ADD_Q: begin
                sum_next = sum_q;
            end
            pnt_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_perf_next  = perf_reg;
                    out_value_next = n_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pnt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        dvd_reg       <= dvd_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        perf_reg      <= perf_next;
        out_perf_reg  <= out_perf_next;
        out_value_reg <= out_value_next;
    end

    assign s_ready        = state_reg == pnt_pkg::ST_IDLE;
    assign m_valid        = out_valid_reg;
    assign m_is_perfect   = out_perf_reg;
    assign m_tested_value = out_value_reg;

endmodule

### sv/pnt_checker.sv
// Port checker for the perfect number test and its bind statement.
`include "perfect_number_test_defines.svh"

module pnt_checker #(
    parameter int NUMBER_WIDTH = 31
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [NUMBER_WIDTH-1:0] s_candidate,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_is_perfect,
    input logic [NUMBER_WIDTH-1:0] m_tested_value
);

    // A stalled result word keeps its value.
    `PNT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_tested_value) && $stable(m_is_perfect), "result word changed while stalled")

    // The block works on one word at a time.
    `PNT_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input accepted while a word is in work")

    // Every perfect number in range is even and at least six.
    `PNT_ASSERT_ALWAYS(a_perfect_even, aclk, m_valid && m_is_perfect |-> !m_tested_value[0] && m_tested_value >= NUMBER_WIDTH'(6), "perfect flag on an impossible value")

    // An accepted candidate word carries no unknown bits.
    `PNT_ASSERT(a_candidate_known, aclk, aresetn, s_valid && s_ready |-> !$isunknown(s_candidate), "unknown candidate accepted")

endmodule

bind perfect_number_test pnt_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_pnt_checker (.*);

### dv/tb_perfect_number_test.sv
// Self-checking testbench for the perfect number test block.
module tb_perfect_number_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = 31;
    localparam int RANDOM_WORDS = 80;
    localparam int IDLE_PCT = 12;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        bit          is_perfect;
        bit [NW-1:0] value;
    } verdict_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [NW-1:0] s_candidate = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_is_perfect;
    logic [NW-1:0] m_tested_value;

    bit [NW-1:0]   candidate_q[$];
    verdict_t      verdict_q[$];
    int            total_words;
    int            words_sent;
    int            results_checked;
    int            perfect_seen;
    int            error_count;
    longint        cycle_count;
    longint        cycle_budget;
    longint        cycle_limit;

    perfect_number_test #(.NUMBER_WIDTH(NW)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_candidate   (s_candidate),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_perfect  (m_is_perfect),
        .m_tested_value(m_tested_value)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Sums proper divisors in pairs up to the square root.
    function automatic bit divisor_sum_is_perfect(input bit [NW-1:0] n);
        longint unsigned v;
        longint unsigned sum;
        longint unsigned d;
        longint unsigned q;
        v = n;
        sum = 0;
        if (v < 2) return 1'b0;
        for (d = 1; d * d <= v; d++) begin
            if (v % d == 0) begin
                q = v / d;
                sum += d;
                if (q != d && q != v) sum += q;
            end
        end
        return sum == v;
    endfunction

    // Queues a candidate and adds its worst-case trial cost to the cycle budget.
    task automatic queue_candidate(input bit [NW-1:0] n);
        longint unsigned root;
        root = 0;
        while ((root + 1) * (root + 1) <= longint'(n)) root++;
        candidate_q.push_back(n);
        cycle_budget += (root + 2) * (NW + 3) + 40;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // Driver: presents queued words and records the prediction when one is taken.
    always @(posedge aclk) begin
        verdict_t v;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                v.is_perfect = divisor_sum_is_perfect(s_candidate);
                v.value = s_candidate;
                verdict_q.push_back(v);
                words_sent++;
            end
            if (!s_valid || s_ready) begin
                if (candidate_q.size() != 0 &&
                    ((words_sent >= 40 && words_sent < 70) || $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_candidate <= candidate_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted result word against the oldest prediction.
    always @(posedge aclk) begin
        verdict_t v;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected result, tested_value", m_tested_value, -1);
                end else begin
                    v = verdict_q.pop_front();
                    results_checked++;
                    if (v.is_perfect) perfect_seen++;
                    if (m_is_perfect !== v.is_perfect)
                        report_mismatch($sformatf("is_perfect for %0d", v.value),
                                        m_is_perfect, v.is_perfect);
                    if (m_tested_value !== v.value)
                        report_mismatch("tested_value", m_tested_value, v.value);
                end
            end
            m_ready <= (results_checked >= 40 && results_checked < 70) ||
                       ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, verdict_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int pick;
        bit [NW-1:0] n;
        cycle_budget = 0;

        // Directed: zero, one, small primes, abundant and deficient numbers,
        // the perfect numbers that fit, the neighbors of the four smallest, and the largest value.
        queue_candidate(0);
        queue_candidate(1);
        queue_candidate(2);
        queue_candidate(3);
        queue_candidate(4);
        queue_candidate(5);
        queue_candidate(6);
        queue_candidate(7);
        queue_candidate(12);
        queue_candidate(27);
        queue_candidate(28);
        queue_candidate(29);
        queue_candidate(495);
        queue_candidate(496);
        queue_candidate(497);
        queue_candidate(8127);
        queue_candidate(8128);
        queue_candidate(8129);
        queue_candidate(65536);
        queue_candidate(33550336);
        queue_candidate({NW{1'b1}});

        // Random: mostly small numbers so each search stays short, some near
        // the perfect numbers, and a few of medium size.
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                case ($urandom_range(3))
                    0: n = 6;
                    1: n = 28;
                    2: n = 496;
                    default: n = 8128;
                endcase
                n = NW'(n + $urandom_range(2) - 1);
            end else if (pick < 35) begin
                n = NW'($urandom_range(262143, 4096));
            end else begin
                n = NW'($urandom_range(4095));
            end
            queue_candidate(n);
        end
        total_words = candidate_q.size();
        cycle_limit = 4 * cycle_budget + 20000;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_sent < total_words || verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Tested %0d candidates and checked %0d results, %0d of them perfect,",
                 words_sent, results_checked, perfect_seen);
        $display("with random stalls on both channels; %0d mismatches.", error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
